// ----- design/ftrc_pkg.sv -----
// ----------------------------------------------------------------------------
// ftrc_pkg: shared types and constants for the five-tuple rule classifier
// Holds transaction structs, operation and status codes, table geometry.
// ----------------------------------------------------------------------------
package ftrc_pkg;

	localparam int RULES_PER_TABLE = 64;
	localparam int INSTANCES       = 4;
	localparam int AUTO_ID_STEP    = 5;
	localparam int TOTAL_SLOTS     = RULES_PER_TABLE * INSTANCES;
	localparam int SLOT_W          = $clog2(RULES_PER_TABLE);
	localparam int CNT_W           = $clog2(RULES_PER_TABLE + 1);
	localparam int INST_W          = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
	localparam int ADDR_W          = $clog2(TOTAL_SLOTS);
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [2:0] {
		KIND_ADD     = 3'd0,
		KIND_DELETE  = 3'd1,
		KIND_MOD_SET = 3'd2,
		KIND_MOD_CLR = 3'd3,
		KIND_MATCH   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  instance_req;
		logic [15:0] rule_id;
		logic [4:0]  field_mask;
		logic [31:0] src_addr;
		logic [5:0]  src_len;
		logic [31:0] dst_addr;
		logic [5:0]  dst_len;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  proto;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] result_id;
		logic [2:0]  status;
	} rsp_t;

	// one stored rule, one memory word
	typedef struct packed {
		logic [15:0] key;
		logic [4:0]  enables;
		logic [5:0]  src_len;
		logic [31:0] src_addr;
		logic [5:0]  dst_len;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  proto;
	} rule_t;

	localparam int RULE_W = $bits(rule_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LAST_RD,
		S_LAST_WT,
		S_DECIDE,
		S_SCAN,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_WRITE,
		S_DONE
	} state_t;

	function automatic logic [5:0] sat_len(input logic [5:0] len);
		sat_len = (len > 6'd32) ? 6'd32 : len;
	endfunction

	function automatic logic prefix_hit(input logic [31:0] pa, input logic [5:0] plen,
			input logic [31:0] addr);
		logic [5:0]  l;
		logic [31:0] m;
		l = sat_len(plen);
		m = (l == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - l));
		prefix_hit = ((pa ^ addr) & m) == 32'h0;
	endfunction

	function automatic logic rule_hit(input rule_t r, input req_t q);
		rule_hit = (!r.enables[0] || prefix_hit(r.src_addr, r.src_len, q.src_addr)) &&
			(!r.enables[1] || prefix_hit(r.dst_addr, r.dst_len, q.dst_addr)) &&
			(!r.enables[2] || r.src_port == q.src_port) &&
			(!r.enables[3] || r.dst_port == q.dst_port) &&
			(!r.enables[4] || r.proto == q.proto);
	endfunction

endpackage

// ----- design/ftrc_ram.sv -----
// ----------------------------------------------------------------------------
// ftrc_ram: generic single-port-write, single-port-read RAM
// Registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module ftrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/ftrc_front.sv -----
// ----------------------------------------------------------------------------
// ftrc_front: request intake queue
// Two-entry queue that takes transactions while the engine is busy.
// ----------------------------------------------------------------------------
module ftrc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ftrc_pkg::req_t  in_data,
	output logic            q_valid,
	input  logic            q_ready,
	output ftrc_pkg::req_t  q_data
);

	ftrc_pkg::req_t buf_q [ftrc_pkg::QUEUE_DEPTH];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = buf_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ready)
		else $error("queue accepted while full");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("queue pop lost");

endmodule

// ----- design/ftrc_engine.sv -----
// ----------------------------------------------------------------------------
// ftrc_engine: rule table sequencer
// Runs search, sorted insert, delete, modify and match over the rule RAM.
// ----------------------------------------------------------------------------
module ftrc_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  ftrc_pkg::req_t  q_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ftrc_pkg::rsp_t  out_data
);

	ftrc_pkg::state_t state_q, state_d;
	ftrc_pkg::req_t   req_q;
	ftrc_pkg::rsp_t   rsp_q;
	logic             rsp_vld_q;
	logic [ftrc_pkg::CNT_W-1:0] count_q [ftrc_pkg::INSTANCES];
	logic [ftrc_pkg::CNT_W-1:0] cnt_q;     // count of the active table
	logic [ftrc_pkg::CNT_W-1:0] idx_q;     // scan/shift index
	logic [ftrc_pkg::CNT_W-1:0] pos_q;     // found or insert slot
	logic             found_q;
	logic [16:0]      id_q;
	logic [ftrc_pkg::INST_W-1:0] inst_q;

	logic             we;
	logic [ftrc_pkg::ADDR_W-1:0] waddr, raddr;
	ftrc_pkg::rule_t  wdata, rdata;
	logic [ftrc_pkg::CNT_W-1:0] ridx;
	logic             rd_ok_q;             // rdata holds slot idx_q-1

	ftrc_pkg::rule_t  new_rule, mod_rule;
	logic             take;

	ftrc_pkg::rsp_t   dec_rsp;
	logic             go_shift_dn, go_shift_up, go_write;

	ftrc_ram #(.WIDTH(ftrc_pkg::RULE_W), .DEPTH(ftrc_pkg::TOTAL_SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	function automatic logic [ftrc_pkg::ADDR_W-1:0] slot_addr(
			input logic [ftrc_pkg::INST_W-1:0] i, input logic [ftrc_pkg::CNT_W-1:0] s);
		slot_addr = ftrc_pkg::ADDR_W'(i) * ftrc_pkg::ADDR_W'(ftrc_pkg::RULES_PER_TABLE) +
			ftrc_pkg::ADDR_W'(s[ftrc_pkg::SLOT_W-1:0]);
	endfunction

	assign q_ready = (state_q == ftrc_pkg::S_IDLE) && !rsp_vld_q;
	assign take    = q_valid && q_ready;
	assign out_valid = rsp_vld_q;
	assign out_data  = rsp_q;

	// fresh rule from the request
	always_comb begin
		new_rule.key      = id_q[15:0];
		new_rule.enables  = req_q.field_mask;
		new_rule.src_len  = ftrc_pkg::sat_len(req_q.src_len);
		new_rule.src_addr = req_q.src_addr;
		new_rule.dst_len  = ftrc_pkg::sat_len(req_q.dst_len);
		new_rule.dst_addr = req_q.dst_addr;
		new_rule.src_port = req_q.src_port;
		new_rule.dst_port = req_q.dst_port;
		new_rule.proto    = req_q.proto;
	end

	// modified copy of the found rule (rdata holds it in S_WRITE)
	always_comb begin
		logic clr;
		clr = (req_q.kind == ftrc_pkg::KIND_MOD_CLR);
		mod_rule = rdata;
		if (req_q.field_mask[0]) begin
			mod_rule.src_len  = clr ? 6'd0 : new_rule.src_len;
			mod_rule.src_addr = clr ? 32'd0 : new_rule.src_addr;
		end
		if (req_q.field_mask[1]) begin
			mod_rule.dst_len  = clr ? 6'd0 : new_rule.dst_len;
			mod_rule.dst_addr = clr ? 32'd0 : new_rule.dst_addr;
		end
		if (req_q.field_mask[2]) mod_rule.src_port = clr ? 16'd0 : req_q.src_port;
		if (req_q.field_mask[3]) mod_rule.dst_port = clr ? 16'd0 : req_q.dst_port;
		if (req_q.field_mask[4]) mod_rule.proto = clr ? 8'd0 : req_q.proto;
		mod_rule.enables = clr ? (rdata.enables & ~req_q.field_mask)
			: (rdata.enables | req_q.field_mask);
	end

	// response and follow-up work once the scan is over
	always_comb begin
		dec_rsp.hit       = 1'b0;
		dec_rsp.result_id = id_q[15:0];
		dec_rsp.status    = ftrc_pkg::ST_OK;
		go_shift_dn       = 1'b0;
		go_shift_up       = 1'b0;
		go_write          = 1'b0;
		unique case (req_q.kind)
			ftrc_pkg::KIND_MATCH: begin
				dec_rsp.hit       = found_q;
				dec_rsp.result_id = found_q ? id_q[15:0] : 16'd0;
				dec_rsp.status    = found_q ? ftrc_pkg::ST_OK : ftrc_pkg::ST_NOT_FOUND;
			end
			ftrc_pkg::KIND_DELETE: begin
				if (!found_q) dec_rsp.status = ftrc_pkg::ST_NOT_FOUND;
				else go_shift_dn = 1'b1;
			end
			ftrc_pkg::KIND_ADD, ftrc_pkg::KIND_MOD_SET, ftrc_pkg::KIND_MOD_CLR: begin
				if (id_q[16]) begin
					dec_rsp.result_id = 16'd0;
					dec_rsp.status    = ftrc_pkg::ST_OVERFLOW;
				end else if (found_q) begin
					if (req_q.kind == ftrc_pkg::KIND_ADD)
						dec_rsp.status = ftrc_pkg::ST_EXISTS;
					else
						go_write = 1'b1; // rdata = slot pos_q next
				end else if (cnt_q >= ftrc_pkg::CNT_W'(ftrc_pkg::RULES_PER_TABLE)) begin
					dec_rsp.status = ftrc_pkg::ST_FULL;
				end else begin
					go_shift_up = 1'b1;
				end
			end
			default: dec_rsp.result_id = 16'd0;
		endcase
	end

	// read address per state
	always_comb begin
		ridx = idx_q;
		unique case (state_q)
			ftrc_pkg::S_LAST_RD:  ridx = cnt_q - 1'b1;
			ftrc_pkg::S_SHIFT_UP: ridx = idx_q - 1'b1;
			ftrc_pkg::S_SHIFT_DN: ridx = idx_q + 1'b1;
			ftrc_pkg::S_DECIDE:   ridx = pos_q;
			default:              ridx = idx_q;
		endcase
		raddr = slot_addr(inst_q, ridx);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ftrc_pkg::S_IDLE:
				if (take) state_d = ftrc_pkg::S_LAST_RD;
			ftrc_pkg::S_LAST_RD: state_d = ftrc_pkg::S_LAST_WT;
			ftrc_pkg::S_LAST_WT: state_d = ftrc_pkg::S_SCAN;
			ftrc_pkg::S_SCAN:
				if (rd_ok_q && idx_q > cnt_q) state_d = ftrc_pkg::S_DECIDE;
				else if (found_q) state_d = ftrc_pkg::S_DECIDE;
			ftrc_pkg::S_DECIDE:
				if (go_shift_dn) state_d = ftrc_pkg::S_SHIFT_DN;
				else if (go_write) state_d = ftrc_pkg::S_WRITE;
				else if (go_shift_up) state_d = ftrc_pkg::S_SHIFT_UP;
				else state_d = ftrc_pkg::S_DONE;
			ftrc_pkg::S_SHIFT_UP:
				if (idx_q == pos_q) state_d = ftrc_pkg::S_WRITE;
			ftrc_pkg::S_SHIFT_DN:
				if (idx_q + 1'b1 >= cnt_q) state_d = ftrc_pkg::S_DONE;
			ftrc_pkg::S_WRITE: state_d = ftrc_pkg::S_DONE;
			ftrc_pkg::S_DONE: state_d = ftrc_pkg::S_IDLE;
			default: state_d = ftrc_pkg::S_IDLE;
		endcase
	end

	// RAM write port
	always_comb begin
		we    = 1'b0;
		waddr = slot_addr(inst_q, idx_q);
		wdata = new_rule;
		unique case (state_q)
			ftrc_pkg::S_SHIFT_UP: begin
				// rdata holds slot idx_q-1 once rd_ok_q is set
				we    = rd_ok_q && (idx_q != pos_q);
				wdata = rdata;
			end
			ftrc_pkg::S_SHIFT_DN: begin
				we    = rd_ok_q;
				wdata = rdata;
			end
			ftrc_pkg::S_WRITE: begin
				we    = 1'b1;
				waddr = slot_addr(inst_q, pos_q);
				wdata = found_q ? mod_rule : new_rule;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) req_q <= q_data;
	end

	// sequencing; rd_ok_q marks that rdata is valid for the address issued last cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ftrc_pkg::S_IDLE;
			rsp_vld_q <= 1'b0;
			rsp_q     <= '0;
			for (int i = 0; i < ftrc_pkg::INSTANCES; i++) count_q[i] <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
			found_q <= 1'b0;
			id_q    <= '0;
			inst_q  <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ftrc_pkg::S_DONE) rsp_vld_q <= 1'b1;
			else if (rsp_vld_q && out_ready) rsp_vld_q <= 1'b0;
			unique case (state_q)
				ftrc_pkg::S_IDLE: if (take) begin
					// instance numbers wrap at the table count, a power of two
					inst_q  <= q_data.instance_req[ftrc_pkg::INST_W-1:0];
					cnt_q   <= count_q[q_data.instance_req[ftrc_pkg::INST_W-1:0]];
					found_q <= 1'b0;
					rd_ok_q <= 1'b0;
				end
				ftrc_pkg::S_LAST_RD: ;
				ftrc_pkg::S_LAST_WT: begin
					// rdata = last rule; settle the ID and start the scan
					if (req_q.rule_id == 16'd0 && req_q.kind != ftrc_pkg::KIND_DELETE)
						id_q <= (cnt_q == '0) ? 17'd1
							: {1'b0, rdata.key} + 17'(ftrc_pkg::AUTO_ID_STEP);
					else
						id_q <= {1'b0, req_q.rule_id};
					idx_q   <= '0;
					pos_q   <= cnt_q;
					rd_ok_q <= 1'b0;
				end
				ftrc_pkg::S_SCAN: begin
					// rdata holds slot idx_q-1 when rd_ok_q
					rd_ok_q <= !(found_q || (rd_ok_q && idx_q > cnt_q));
					idx_q   <= idx_q + 1'b1;
					if (rd_ok_q && (idx_q - 1'b1) < cnt_q && !found_q) begin
						if (req_q.kind == ftrc_pkg::KIND_MATCH) begin
							if (ftrc_pkg::rule_hit(rdata, req_q)) begin
								found_q <= 1'b1;
								pos_q   <= idx_q - 1'b1;
								id_q    <= {1'b0, rdata.key};
							end
						end else if (!(req_q.rule_id == 16'd0 &&
								req_q.kind != ftrc_pkg::KIND_DELETE)) begin
							if (rdata.key == id_q[15:0]) begin
								found_q <= 1'b1;
								pos_q   <= idx_q - 1'b1;
							end else if (rdata.key > id_q[15:0] && pos_q == cnt_q) begin
								pos_q <= idx_q - 1'b1;
							end
						end
					end
				end
				ftrc_pkg::S_DECIDE: begin
					rsp_q   <= dec_rsp;
					rd_ok_q <= 1'b0;
					if (go_shift_dn) idx_q <= pos_q;
					else if (go_shift_up) idx_q <= cnt_q;
				end
				ftrc_pkg::S_SHIFT_UP: begin
					// read idx-1 this cycle, write it to idx next cycle
					if (idx_q == pos_q) begin
						count_q[inst_q] <= cnt_q + 1'b1;
						rd_ok_q         <= 1'b0;
					end else if (rd_ok_q) begin
						rd_ok_q <= 1'b0;
						idx_q   <= idx_q - 1'b1;
					end else begin
						rd_ok_q <= 1'b1;
					end
				end
				ftrc_pkg::S_SHIFT_DN: begin
					if (idx_q + 1'b1 >= cnt_q) begin
						count_q[inst_q] <= cnt_q - 1'b1;
					end else if (rd_ok_q) begin
						rd_ok_q <= 1'b0;
						idx_q   <= idx_q + 1'b1;
					end else begin
						rd_ok_q <= 1'b1;
					end
				end
				ftrc_pkg::S_WRITE: ;
				ftrc_pkg::S_DONE: ;
				default: ;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q |-> !q_ready)
		else $error("took a transaction with a response pending");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ftrc_pkg::CNT_W'(ftrc_pkg::RULES_PER_TABLE))
		else $error("table count past capacity");
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_q.hit |-> rsp_q.status == ftrc_pkg::ST_OK)
		else $error("hit with bad status");

endmodule

// ----- design/five_tuple_rule_classifier.sv -----
// ----------------------------------------------------------------------------
// five_tuple_rule_classifier: first-match IPv4 five-tuple rule tables
// Search, match and modify walk the chosen table; insert and delete also shift
// the rules behind the chosen slot, one rule at a time, paced by the rule RAM.
// The engine takes a new transaction only after the last response is accepted.
// Reset (arst_n low) empties all tables at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module five_tuple_rule_classifier (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ftrc_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ftrc_pkg::rsp_t  out_data
);

	// hand-off between intake queue and table engine
	logic           q_valid, q_ready;
	ftrc_pkg::req_t q_data;

	// front: hold requests while the engine works
	ftrc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data)
	);

	// back: walk the rule RAM, one slot per cycle while scanning, and answer
	ftrc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- sim/five_tuple_rule_classifier_tb.sv -----
// ----------------------------------------------------------------------------
// five_tuple_rule_classifier_tb: self-checking bench for the rule classifier
// Drives add, delete, modify and match transactions in random bursts, keeps a
// shadow copy of every rule table and checks each response in order.
// ----------------------------------------------------------------------------
module five_tuple_rule_classifier_tb;

	localparam int WATCHDOG_LIMIT = 20000;

	// Shadow copy of one stored rule.
	typedef struct {
		logic [15:0] key;
		logic [4:0]  enables;
		logic [5:0]  src_len;
		logic [31:0] src_addr;
		logic [5:0]  dst_len;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  proto;
	} shadow_rule_t;

	class rule_table_scoreboard;
		shadow_rule_t   tables[ftrc_pkg::INSTANCES][$];
		ftrc_pkg::rsp_t pending[$];
		int             errors;
		int             checked;
		int             hits;

		function automatic logic [5:0] clip_len(logic [5:0] len);
			return (len > 6'd32) ? 6'd32 : len;
		endfunction

		function automatic bit addr_in_prefix(logic [31:0] pa, logic [5:0] plen,
				logic [31:0] addr);
			logic [31:0] m;
			m = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
			return ((pa ^ addr) & m) == 32'h0;
		endfunction

		function automatic shadow_rule_t fresh_rule(ftrc_pkg::req_t q, logic [15:0] key);
			shadow_rule_t r;
			r.key = key;
			r.enables = q.field_mask;
			r.src_len = clip_len(q.src_len);
			r.src_addr = q.src_addr;
			r.dst_len = clip_len(q.dst_len);
			r.dst_addr = q.dst_addr;
			r.src_port = q.src_port;
			r.dst_port = q.dst_port;
			r.proto = q.proto;
			return r;
		endfunction

		// Predict the response to one accepted request and update the tables.
		function void note_request(ftrc_pkg::req_t q);
			ftrc_pkg::rsp_t e;
			int          inst, cnt, slot, pos;
			logic [16:0] id;
			bit          clr;
			shadow_rule_t r;
			inst = q.instance_req % ftrc_pkg::INSTANCES;
			cnt = tables[inst].size();
			e = '0;
			id = {1'b0, q.rule_id};
			slot = -1;
			for (int s = 0; s < cnt; s++)
				if (tables[inst][s].key == q.rule_id) slot = s;
			case (q.kind)
				ftrc_pkg::KIND_ADD, ftrc_pkg::KIND_MOD_SET, ftrc_pkg::KIND_MOD_CLR: begin
					if (q.rule_id == 0) begin
						slot = -1;
						id = (cnt == 0) ? 17'd1 : 17'(tables[inst][cnt-1].key) +
							17'(ftrc_pkg::AUTO_ID_STEP);
					end
					if (id > 17'hFFFF) begin
						e.status = ftrc_pkg::ST_OVERFLOW;
					end else if (slot >= 0) begin
						e.result_id = id[15:0];
						if (q.kind == ftrc_pkg::KIND_ADD) begin
							e.status = ftrc_pkg::ST_EXISTS;
						end else begin
							clr = (q.kind == ftrc_pkg::KIND_MOD_CLR);
							r = tables[inst][slot];
							if (q.field_mask[0]) begin
								r.src_len = clr ? 6'd0 : clip_len(q.src_len);
								r.src_addr = clr ? 32'd0 : q.src_addr;
							end
							if (q.field_mask[1]) begin
								r.dst_len = clr ? 6'd0 : clip_len(q.dst_len);
								r.dst_addr = clr ? 32'd0 : q.dst_addr;
							end
							if (q.field_mask[2]) r.src_port = clr ? 16'd0 : q.src_port;
							if (q.field_mask[3]) r.dst_port = clr ? 16'd0 : q.dst_port;
							if (q.field_mask[4]) r.proto = clr ? 8'd0 : q.proto;
							r.enables = clr ? (r.enables & ~q.field_mask)
								: (r.enables | q.field_mask);
							tables[inst][slot] = r;
						end
					end else begin
						e.result_id = id[15:0];
						if (cnt >= ftrc_pkg::RULES_PER_TABLE) begin
							e.status = ftrc_pkg::ST_FULL;
						end else begin
							pos = 0;
							while (pos < cnt && tables[inst][pos].key < id[15:0]) pos++;
							tables[inst].insert(pos, fresh_rule(q, id[15:0]));
						end
					end
				end
				ftrc_pkg::KIND_DELETE: begin
					e.result_id = q.rule_id;
					if (slot >= 0) tables[inst].delete(slot);
					else e.status = ftrc_pkg::ST_NOT_FOUND;
				end
				ftrc_pkg::KIND_MATCH: begin
					e.status = ftrc_pkg::ST_NOT_FOUND;
					foreach (tables[inst][s]) begin
						r = tables[inst][s];
						if (r.enables[0] && !addr_in_prefix(r.src_addr, r.src_len, q.src_addr))
							continue;
						if (r.enables[1] && !addr_in_prefix(r.dst_addr, r.dst_len, q.dst_addr))
							continue;
						if (r.enables[2] && r.src_port != q.src_port) continue;
						if (r.enables[3] && r.dst_port != q.dst_port) continue;
						if (r.enables[4] && r.proto != q.proto) continue;
						e.hit = 1'b1;
						e.result_id = r.key;
						e.status = ftrc_pkg::ST_OK;
						break;
					end
				end
				default: ;
			endcase
			pending.push_back(e);
		endfunction

		task check_response(ftrc_pkg::rsp_t got);
			ftrc_pkg::rsp_t e;
			checked++;
			if (pending.size() == 0) begin
				report_mismatch("unexpected response", 0, got.status);
				return;
			end
			e = pending.pop_front();
			if (got.hit) hits++;
			if (got.hit !== e.hit) report_mismatch("hit", e.hit, got.hit);
			if (got.result_id !== e.result_id)
				report_mismatch("result_id", e.result_id, got.result_id);
			if (got.status !== e.status) report_mismatch("status", e.status, got.status);
		endtask
	endclass

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	ftrc_pkg::req_t in_data;
	logic           out_valid;
	logic           out_ready;
	ftrc_pkg::rsp_t out_data;

	rule_table_scoreboard board;
	int   error_count;
	int   sent;
	int   idle_cycles;
	bit   stim_done;

	five_tuple_rule_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		error_count++;
		$display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want, got);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sample both handshakes at the edge; hand accepted requests to the predictor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) board.note_request(in_data);
			if (out_valid && out_ready) board.check_response(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	// Stall the response side on its own pattern, with calm stretches.
	initial begin
		int mode;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 1) != 0);
					default: out_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("five_tuple_rule_classifier verification failed");
				$finish;
			end
		end
	end

	// Hold the request until it is accepted; the caller drops valid before idling.
	task automatic send_request(ftrc_pkg::req_t q);
		in_valid <= 1'b1;
		in_data <= q;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	// Between bursts, idle a random gap; sometimes none.
	task automatic send_with_gaps(ftrc_pkg::req_t q, ref int burst_left);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
		burst_left--;
		send_request(q);
	endtask

	function automatic ftrc_pkg::req_t random_request();
		ftrc_pkg::req_t q;
		q.kind = ftrc_pkg::kind_t'($urandom_range(0, 4));
		if ($urandom_range(0, 40) == 0) q.kind = 3'($urandom_range(5, 7));
		q.instance_req = 2'($urandom_range(0, 3));
		q.rule_id = ($urandom_range(0, 9) == 0) ? 16'd0
			: ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 90));
		q.field_mask = 5'($urandom_range(0, 31));
		q.src_addr = {8'd10, 16'($urandom_range(0, 3)), 8'($urandom)};
		q.dst_addr = {8'd192, 16'($urandom_range(0, 3)), 8'($urandom)};
		if ($urandom_range(0, 7) == 0) q.src_addr = $urandom;
		if ($urandom_range(0, 7) == 0) q.dst_addr = $urandom;
		q.src_len = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(33, 63))
			: 6'($urandom_range(0, 32));
		q.dst_len = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(33, 63))
			: 6'($urandom_range(0, 32));
		q.src_port = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		q.dst_port = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		q.proto = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(6, 7));
		return q;
	endfunction

	// Drop valid and hold off until every predicted response is back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		ftrc_pkg::req_t q;
		int   burst;
		int   phase_len;
		board = new();
		error_count = 0;
		sent = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation and the corner cases.
		q = '0; q.kind = ftrc_pkg::KIND_MATCH;       send_request(q); // empty table miss
		q = '0; q.kind = ftrc_pkg::KIND_ADD;         send_request(q); // auto ID on empty
		q = '0; q.kind = ftrc_pkg::KIND_ADD;  q.rule_id = 16'hFFFF; q.field_mask = 5'h1F;
		q.src_addr = 32'hFFFF_FFFF; q.src_len = 6'd63; q.dst_addr = 32'hFFFF_FFFF;
		q.dst_len = 6'd32; q.src_port = 16'hFFFF; q.dst_port = 16'hFFFF; q.proto = 8'hFF;
		send_request(q);
		send_request(q);                                               // duplicate
		q.kind = ftrc_pkg::KIND_MATCH;               send_request(q); // exact hit
		q.proto = 8'h00;                             send_request(q); // miss on proto
		q = '0; q.kind = ftrc_pkg::KIND_ADD;         send_request(q); // auto ID overflow
		q = '0; q.kind = ftrc_pkg::KIND_DELETE; q.rule_id = 16'd0; send_request(q); // absent ID 0
		q.rule_id = 16'hFFFF;                        send_request(q);
		send_request(q);                                               // now absent
		q = '0; q.kind = ftrc_pkg::KIND_MOD_CLR; q.rule_id = 16'd7; q.field_mask = 5'h05;
		q.src_addr = 32'h0A00_0000; q.src_len = 6'd8; q.src_port = 16'd80;
		send_request(q);                                               // insert on clear
		q.kind = ftrc_pkg::KIND_MOD_SET; q.field_mask = 5'h1A; q.dst_addr = 32'hC0A8_0000;
		q.dst_len = 6'd16; q.dst_port = 16'd443; q.proto = 8'd6;
		send_request(q);
		q.kind = ftrc_pkg::KIND_MOD_CLR; q.field_mask = 5'h01; send_request(q);
		q.kind = ftrc_pkg::KIND_MATCH; q.dst_addr = 32'hC0A8_1234; send_request(q);
		q = '0; q.kind = ftrc_pkg::KIND_MOD_SET;     send_request(q); // auto ID modify
		q = '0; q.kind = 3'd6; q.instance_req = 2'd3; send_request(q); // unused kind
		q = '0; q.kind = ftrc_pkg::KIND_MATCH; q.instance_req = 2'd2; send_request(q);
		// Fill instance 1 to the brim, then overflow it.
		for (int i = 0; i < ftrc_pkg::RULES_PER_TABLE + 1; i++) begin
			q = random_request(); q.kind = ftrc_pkg::KIND_ADD; q.instance_req = 2'd1;
			q.rule_id = 16'(1000 - i);
			send_request(q);
		end
		q.kind = ftrc_pkg::KIND_MOD_SET; q.rule_id = 16'd5; send_request(q); // full on modify
		wait_drained();                                                // sender pause

		// Random phases; table 1 is drained of its bulk by deletes.
		burst = 0;
		for (int p = 0; p < 8; p++) begin
			phase_len = 200;
			for (int i = 0; i < phase_len; i++) begin
				q = random_request();
				if (p == 0 && i < 64) begin
					q.kind = ftrc_pkg::KIND_DELETE; q.instance_req = 2'd1;
					q.rule_id = 16'(1000 - i);
				end else if (p[0] && q.kind == ftrc_pkg::KIND_DELETE) begin
					q.kind = ftrc_pkg::KIND_ADD; // let tables grow in odd phases
				end
				send_with_gaps(q, burst);
			end
			if (p == 3) wait_drained();
		end

		wait_drained();
		repeat (300) @(posedge clk);
		$display("covered %0d requests, %0d responses checked, %0d match hits",
			sent, board.checked, board.hits);
		error_count += board.pending.size();
		if (error_count == 0)
			$display("five_tuple_rule_classifier verification clean");
		else
			$display("five_tuple_rule_classifier verification failed");
		$finish;
	end
endmodule
